### rtl/dftm_pkg.sv
`default_nettype none

package dftm_pkg;

  // Fan pulse counter and lamp PWM counter widths.
  localparam int unsigned COUNT_WIDTH = 16;
  localparam int unsigned PWM_WIDTH   = 8;

  // Fixed widths of the configuration fields.
  localparam int unsigned MIN_WIDTH   = 16;
  localparam int unsigned LEVEL_WIDTH = 8;
  localparam int unsigned SPUR_WIDTH  = 8;
  localparam int unsigned CFG_IDX_WIDTH  = 3;
  localparam int unsigned CFG_DATA_WIDTH = 16;

  // Compare widths wide enough for either operand (and the unwrapped sum).
  localparam int unsigned SUM_WIDTH = COUNT_WIDTH + 1;
  localparam int unsigned CMP_WIDTH = (SUM_WIDTH > MIN_WIDTH) ? SUM_WIDTH : MIN_WIDTH;
  localparam int unsigned PWM_CMP_WIDTH =
    (PWM_WIDTH > LEVEL_WIDTH) ? PWM_WIDTH : LEVEL_WIDTH;

  // Reset values of the configuration registers.
  localparam logic [MIN_WIDTH-1:0]   FAN1_MIN_RESET  = MIN_WIDTH'(10);
  localparam logic [MIN_WIDTH-1:0]   FAN2_MIN_RESET  = MIN_WIDTH'(10);
  localparam logic [MIN_WIDTH-1:0]   TOTAL_MIN_RESET = MIN_WIDTH'(20);
  localparam logic [SPUR_WIDTH-1:0]  SPUR_LIMIT_RESET = SPUR_WIDTH'(16);
  localparam logic [LEVEL_WIDTH-1:0] LEVEL1_RESET    = LEVEL_WIDTH'(128);
  localparam logic [LEVEL_WIDTH-1:0] LEVEL2_RESET    = LEVEL_WIDTH'(64);

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_WIDTH-1:0] {
    CFG_FAN1_MIN   = 3'd0,
    CFG_FAN2_MIN   = 3'd1,
    CFG_TOTAL_MIN  = 3'd2,
    CFG_SPUR_LIMIT = 3'd3,
    CFG_LEVEL1     = 3'd4,
    CFG_LEVEL2     = 3'd5,
    CFG_ALT_BLINK  = 3'd6
  } cfg_idx_e;

  // Supervisor status codes.
  typedef enum logic [1:0] {
    STAT_WAIT   = 2'd0,
    STAT_LOW    = 2'd1,
    STAT_NORMAL = 2'd2
  } status_e;

  // Bit positions in the lamp and fan flag vectors.
  localparam int unsigned LAMP1_BIT  = 0;
  localparam int unsigned LAMP2_BIT  = 1;
  localparam int unsigned LAMP3_BIT  = 2;
  localparam int unsigned OK1_BIT    = 0;
  localparam int unsigned OK2_BIT    = 1;
  localparam int unsigned NORMAL_BIT = 2;

  typedef struct packed {
    logic tach1_edge;
    logic tach2_edge;
    logic serial_event;
    logic pwm_tick;
    logic window_tick;
  } in_t;

  typedef struct packed {
    logic       lamp1;
    logic       lamp2;
    logic       lamp3;
    logic       relay_on;
    logic       rpm_square;
    logic       fan1_ok;
    logic       fan2_ok;
    logic [1:0] status;
    logic       reset_request;
  } out_t;

  typedef struct packed {
    logic [MIN_WIDTH-1:0]   fan1_min;
    logic [MIN_WIDTH-1:0]   fan2_min;
    logic [MIN_WIDTH-1:0]   total_min;
    logic [SPUR_WIDTH-1:0]  spur_limit;
    logic [LEVEL_WIDTH-1:0] level1;
    logic [LEVEL_WIDTH-1:0] level2;
    logic                   alt_blink;
  } cfg_t;

  typedef struct packed {
    logic [COUNT_WIDTH-1:0] fan1_count;
    logic [COUNT_WIDTH-1:0] fan2_count;
    logic [PWM_WIDTH-1:0]   pwm1_count;
    logic [PWM_WIDTH-1:0]   pwm2_count;
    logic [2:0]             lamp_bits;
    logic [2:0]             lamp_drive;
    logic [2:0]             ok_flags;
    status_e                status;
    logic                   rpm_level;
    logic [SPUR_WIDTH-1:0]  spur_count;
  } state_t;

  localparam state_t STATE_RESET = '{
    fan1_count: '0, fan2_count: '0, pwm1_count: '0, pwm2_count: '0,
    lamp_bits: '0, lamp_drive: '0, ok_flags: '0, status: STAT_WAIT,
    rpm_level: 1'b0, spur_count: '0
  };

endpackage

`default_nettype wire

### rtl/dftm_step.sv
`default_nettype none

module dftm_step
  import dftm_pkg::*;
(
  input  state_t cur_i,
  input  cfg_t   cfg_i,
  input  in_t    item_i,
  output state_t nxt_o,
  output logic   reset_req_o
);

  // Next state for one event: pulses, then PWM tick, then window tick,
  // then the spurious check.
  always_comb begin
    state_t               s;
    logic [PWM_WIDTH-1:0] old1;
    logic [PWM_WIDTH-1:0] old2;
    logic                 was_normal;
    logic                 ok1;
    logic                 ok2;
    logic                 normal;
    logic                 b1;
    logic                 b2;
    logic                 b3;
    logic                 any_flag;
    logic [SPUR_WIDTH-1:0] spur_old;

    s           = cur_i;
    reset_req_o = 1'b0;
    old1        = cur_i.pwm1_count;
    old2        = cur_i.pwm2_count;

    // Saturating tach pulse counters.
    if (item_i.tach1_edge && (s.fan1_count != '1)) begin
      s.fan1_count = s.fan1_count + 1'b1;
    end
    if (item_i.tach2_edge && (s.fan2_count != '1)) begin
      s.fan2_count = s.fan2_count + 1'b1;
    end

    // Lamp PWM: the counter only runs while its blink bit is set.
    if (item_i.pwm_tick) begin
      if (s.lamp_bits[LAMP1_BIT]) begin
        s.pwm1_count = old1 + 1'b1;
        if (PWM_CMP_WIDTH'(old1) >= PWM_CMP_WIDTH'(cfg_i.level1)) begin
          s.lamp_drive[LAMP1_BIT] = 1'b1;
        end
        if (s.pwm1_count == '0) begin
          s.lamp_drive[LAMP1_BIT] = 1'b0;
        end
      end else begin
        s.lamp_drive[LAMP1_BIT] = 1'b0;
      end
      if (s.lamp_bits[LAMP2_BIT]) begin
        s.pwm2_count = old2 + 1'b1;
        if (PWM_CMP_WIDTH'(old2) >= PWM_CMP_WIDTH'(cfg_i.level2)) begin
          s.lamp_drive[LAMP2_BIT] = 1'b1;
        end
        if (s.pwm2_count == '0) begin
          s.lamp_drive[LAMP2_BIT] = 1'b0;
        end
      end else begin
        s.lamp_drive[LAMP2_BIT] = 1'b0;
      end
    end

    // Window close: judge the counts and step the blink pattern.
    was_normal = s.ok_flags[NORMAL_BIT];
    ok1    = CMP_WIDTH'(s.fan1_count) >= CMP_WIDTH'(cfg_i.fan1_min);
    ok2    = CMP_WIDTH'(s.fan2_count) >= CMP_WIDTH'(cfg_i.fan2_min);
    normal = (CMP_WIDTH'(s.fan1_count) + CMP_WIDTH'(s.fan2_count))
             >= CMP_WIDTH'(cfg_i.total_min);
    b1 = s.lamp_bits[LAMP1_BIT];
    b2 = s.lamp_bits[LAMP2_BIT];
    b3 = s.lamp_bits[LAMP3_BIT];
    if (!was_normal) begin
      b1 = ~b1;
      b2 = cfg_i.alt_blink ? ~b1 : ~b2;
    end
    b3 = ~b3;
    if (normal) begin
      b1 = 1'b0;
      b2 = 1'b0;
    end
    if (item_i.window_tick) begin
      s.rpm_level  = ~s.rpm_level;
      s.status     = normal ? STAT_NORMAL : STAT_LOW;
      s.ok_flags   = {normal, ok2, ok1};
      s.fan1_count = '0;
      s.fan2_count = '0;
      s.lamp_bits  = {b3, b2, b1};
      s.lamp_drive = {b3, b2, b1};
    end

    // An event with no flag is spurious; past the limit everything restarts.
    any_flag = item_i.tach1_edge | item_i.tach2_edge | item_i.serial_event
             | item_i.pwm_tick | item_i.window_tick;
    spur_old = cur_i.spur_count;
    if (!any_flag) begin
      if (spur_old != '1) begin
        s.spur_count = spur_old + 1'b1;
      end
      if (spur_old > cfg_i.spur_limit) begin
        s           = STATE_RESET;
        reset_req_o = 1'b1;
      end
    end

    nxt_o = s;
  end

endmodule

`default_nettype wire

### rtl/dual_fan_tach_monitor_top.sv
// The result of an item is registered and appears in the cycle after it is accepted.
// Throughput: one item per cycle; the single output register sets the rate,
// and a new item is taken whenever that register is empty or being emptied.
// Reset: asynchronous, active low; clears all counters, lamps and status,
// and loads the configuration registers with their default values.
`default_nettype none

module dual_fan_tach_monitor_top
  import dftm_pkg::*;
(
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        in_valid_i,
  output logic                       in_ready_o,
  input  in_t                        in_data_i,
  output logic                       out_valid_o,
  input  wire                        out_ready_i,
  output out_t                       out_data_o,
  input  wire                        cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire [CFG_IDX_WIDTH-1:0]    cfg_index_i,
  input  wire [CFG_DATA_WIDTH-1:0]   cfg_data_i
);

  cfg_t   cfg_q;
  cfg_t   cfg_d;
  state_t state_q;
  state_t state_d;
  state_t state_nxt;
  logic   reset_req;
  out_t   out_q;
  out_t   out_d;
  logic   out_valid_q;
  logic   out_valid_d;
  logic   in_fire;

  // Handshakes: an item is taken while the result register can be refilled.
  assign in_ready_o  = !out_valid_q || out_ready_i;
  assign in_fire     = in_valid_i && in_ready_o;
  assign cfg_ready_o = 1'b1;

  // Configuration register decode.
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_valid_i) begin
      unique case (cfg_index_i)
        CFG_FAN1_MIN:   cfg_d.fan1_min   = cfg_data_i[MIN_WIDTH-1:0];
        CFG_FAN2_MIN:   cfg_d.fan2_min   = cfg_data_i[MIN_WIDTH-1:0];
        CFG_TOTAL_MIN:  cfg_d.total_min  = cfg_data_i[MIN_WIDTH-1:0];
        CFG_SPUR_LIMIT: cfg_d.spur_limit = cfg_data_i[SPUR_WIDTH-1:0];
        CFG_LEVEL1:     cfg_d.level1     = cfg_data_i[LEVEL_WIDTH-1:0];
        CFG_LEVEL2:     cfg_d.level2     = cfg_data_i[LEVEL_WIDTH-1:0];
        CFG_ALT_BLINK:  cfg_d.alt_blink  = cfg_data_i[0];
        default:        cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{
        fan1_min: FAN1_MIN_RESET, fan2_min: FAN2_MIN_RESET,
        total_min: TOTAL_MIN_RESET, spur_limit: SPUR_LIMIT_RESET,
        level1: LEVEL1_RESET, level2: LEVEL2_RESET, alt_blink: 1'b1
      };
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // Event processing.
  dftm_step u_step (
    .cur_i       (state_q),
    .cfg_i       (cfg_q),
    .item_i      (in_data_i),
    .nxt_o       (state_nxt),
    .reset_req_o (reset_req)
  );

  assign state_d = in_fire ? state_nxt : state_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= STATE_RESET;
    end else begin
      state_q <= state_d;
    end
  end

  // Result item formed from the state after the event.
  always_comb begin
    out_d.lamp1         = state_nxt.lamp_drive[LAMP1_BIT];
    out_d.lamp2         = state_nxt.lamp_drive[LAMP2_BIT];
    out_d.lamp3         = state_nxt.lamp_drive[LAMP3_BIT];
    out_d.relay_on      = (state_nxt.status == STAT_LOW);
    out_d.rpm_square    = state_nxt.rpm_level;
    out_d.fan1_ok       = state_nxt.ok_flags[OK1_BIT];
    out_d.fan2_ok       = state_nxt.ok_flags[OK2_BIT];
    out_d.status        = state_nxt.status;
    out_d.reset_request = reset_req;
  end

  // Output register; the payload needs no reset.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      out_q <= out_d;
    end
  end

  assign out_valid_d = in_fire ? 1'b1 : (out_ready_i ? 1'b0 : out_valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  // An accepted item always leaves a result in the next cycle.
  a_result_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |=> out_valid_o)
    else $error("accepted item produced no result");

  // A reset request shows the cleared outputs.
  a_reset_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_data_o.reset_request) |->
      (out_data_o.status == STAT_WAIT && !out_data_o.lamp1 && !out_data_o.lamp2
       && !out_data_o.lamp3 && !out_data_o.relay_on && !out_data_o.rpm_square))
    else $error("reset request with stale state");

  // The relay follows a low status exactly.
  a_relay_status: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.relay_on == (out_data_o.status == STAT_LOW)))
    else $error("relay disagrees with status");
`endif

endmodule

`default_nettype wire

### dv/dual_fan_tach_monitor_top_tb.sv
`timescale 1ns / 100ps

module dual_fan_tach_monitor_top_tb;
  import dftm_pkg::*;

  // One row of the directed table: the event, and where the outcome is obvious,
  // the outputs typed in by hand.
  typedef struct packed {
    in_t  ev;
    logic typed;
    out_t want;
  } directed_row_t;

  localparam int unsigned DIRECTED_COUNT = 18;
  localparam out_t QUIET_OUT   = '0;
  localparam out_t CLEARED_OUT = '{reset_request: 1'b1, default: '0};
  localparam int unsigned HOLD_OFF_CYCLES = 200;
  localparam int unsigned PULSE_BURST     = 60;
  localparam int unsigned SPUR_BURST      = 260;

  // Event bits are {fan1, fan2, serial, pwm, window}.
  localparam directed_row_t DIRECTED_ROWS [DIRECTED_COUNT] = '{
    '{5'b00100, 1'b1, QUIET_OUT},
    '{5'b10000, 1'b0, QUIET_OUT},
    '{5'b01000, 1'b0, QUIET_OUT},
    '{5'b11000, 1'b0, QUIET_OUT},
    '{5'b00001, 1'b0, QUIET_OUT},
    '{5'b00010, 1'b0, QUIET_OUT},
    '{5'b00010, 1'b0, QUIET_OUT},
    '{5'b11111, 1'b0, QUIET_OUT},
    '{5'b00000, 1'b0, QUIET_OUT},
    '{5'b00000, 1'b1, CLEARED_OUT},
    '{5'b00001, 1'b0, QUIET_OUT},
    '{5'b00011, 1'b0, QUIET_OUT},
    '{5'b10010, 1'b0, QUIET_OUT},
    '{5'b01001, 1'b0, QUIET_OUT},
    '{5'b00000, 1'b0, QUIET_OUT},
    '{5'b00110, 1'b0, QUIET_OUT},
    '{5'b00000, 1'b1, CLEARED_OUT},
    '{5'b11101, 1'b0, QUIET_OUT}
  };

  localparam int unsigned PHASE_COUNT = 6;
  localparam int unsigned PHASE_ITEMS [PHASE_COUNT] = '{240, 220, 200, 300, 240, 230};

  logic                      clk_i = 1'b0;
  logic                      rst_ni = 1'b0;
  logic                      in_valid_i = 1'b0;
  logic                      in_ready_o;
  in_t                       in_data_i = '0;
  logic                      out_valid_o;
  logic                      out_ready_i = 1'b0;
  out_t                      out_data_o;
  logic                      cfg_valid_i = 1'b0;
  logic                      cfg_ready_o;
  logic [CFG_IDX_WIDTH-1:0]  cfg_index_i = '0;
  logic [CFG_DATA_WIDTH-1:0] cfg_data_i = '0;

  // Hand-typed outputs travel alongside the item they belong to.
  logic row_typed = 1'b0;
  out_t row_want = '0;

  // Monitor model: configuration and state as the block should hold them.
  cfg_t                   regs;
  logic [COUNT_WIDTH-1:0] fan1_cnt, fan2_cnt;
  logic [PWM_WIDTH-1:0]   pwm_cnt [2];
  logic [2:0]             blink_bits, drive_bits, ok_bits;
  status_e                stat;
  logic                   rpm;
  logic [SPUR_WIDTH-1:0]  spur_cnt;

  out_t pending_outputs [$];
  out_t got_out, want_out;

  bit          calm = 1'b0;
  bit          hold_off_req = 1'b0;
  int unsigned hold_cycles = 0;
  int unsigned pulse_pct = 60;
  int unsigned error_count = 0;
  int unsigned events_seen = 0;
  int unsigned results_checked = 0;
  int unsigned windows_done = 0;
  int unsigned normal_windows = 0;
  int unsigned resets_done = 0;

  dual_fan_tach_monitor_top i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  // Counters, lamps and status go back to their power-up values.
  function automatic void clear_fan_state();
    fan1_cnt   = '0;
    fan2_cnt   = '0;
    pwm_cnt[0] = '0;
    pwm_cnt[1] = '0;
    blink_bits = '0;
    drive_bits = '0;
    ok_bits    = '0;
    stat       = STAT_WAIT;
    rpm        = 1'b0;
    spur_cnt   = '0;
  endfunction

  // Applies one event to the model and returns the outputs that follow it.
  function automatic out_t predict_outputs(in_t ev);
    out_t                   o;
    logic [SPUR_WIDTH-1:0]  old_spur;
    logic [PWM_WIDTH-1:0]   nxt;
    logic [LEVEL_WIDTH-1:0] lvl;
    logic [2:0]             nb;
    logic                   was_normal, ok1, ok2, normal_win, req;
    req = 1'b0;

    // Pulses land first, so a pulse arriving with a window tick counts in it.
    if (ev.tach1_edge && fan1_cnt != '1) fan1_cnt++;
    if (ev.tach2_edge && fan2_cnt != '1) fan2_cnt++;

    // Lamp PWM: only lamps whose blink bit is set step their counters.
    if (ev.pwm_tick) begin
      for (int i = 0; i < 2; i++) begin
        lvl = (i == 0) ? regs.level1 : regs.level2;
        if (blink_bits[i]) begin
          nxt = pwm_cnt[i] + 1'b1;
          if (pwm_cnt[i] >= lvl) drive_bits[i] = 1'b1;
          if (nxt == '0) drive_bits[i] = 1'b0;
          pwm_cnt[i] = nxt;
        end else begin
          drive_bits[i] = 1'b0;
        end
      end
    end

    // Window close: judge the counts, then work out the new blink pattern.
    if (ev.window_tick) begin
      was_normal = ok_bits[NORMAL_BIT];
      ok1 = fan1_cnt >= regs.fan1_min;
      ok2 = fan2_cnt >= regs.fan2_min;
      normal_win = (SUM_WIDTH'(fan1_cnt) + SUM_WIDTH'(fan2_cnt)) >= SUM_WIDTH'(regs.total_min);
      rpm = ~rpm;
      stat = normal_win ? STAT_NORMAL : STAT_LOW;
      ok_bits = '0;
      ok_bits[OK1_BIT] = ok1;
      ok_bits[OK2_BIT] = ok2;
      ok_bits[NORMAL_BIT] = normal_win;
      fan1_cnt = '0;
      fan2_cnt = '0;
      nb = blink_bits;
      if (!was_normal) begin
        nb[LAMP1_BIT] = ~nb[LAMP1_BIT];
        nb[LAMP2_BIT] = regs.alt_blink ? ~nb[LAMP1_BIT] : ~nb[LAMP2_BIT];
      end
      nb[LAMP3_BIT] = ~nb[LAMP3_BIT];
      if (normal_win) begin
        nb[LAMP1_BIT] = 1'b0;
        nb[LAMP2_BIT] = 1'b0;
      end
      blink_bits = nb;
      drive_bits = nb;
      windows_done++;
      if (normal_win) normal_windows++;
    end

    // An event with no flag at all is spurious; too many wipe the state.
    if (ev == '0) begin
      old_spur = spur_cnt;
      if (spur_cnt != '1) spur_cnt++;
      if (old_spur > regs.spur_limit) begin
        clear_fan_state();
        req = 1'b1;
        resets_done++;
      end
    end

    o.lamp1         = drive_bits[LAMP1_BIT];
    o.lamp2         = drive_bits[LAMP2_BIT];
    o.lamp3         = drive_bits[LAMP3_BIT];
    o.relay_on      = (stat == STAT_LOW);
    o.rpm_square    = rpm;
    o.fan1_ok       = ok_bits[OK1_BIT];
    o.fan2_ok       = ok_bits[OK2_BIT];
    o.status        = stat;
    o.reset_request = req;
    return o;
  endfunction

  task automatic check_field(input string name, input logic [1:0] want, input logic [1:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected %0d, got %0d", name, want, got);
      error_count++;
    end
  endtask

  // Result checking and prediction, both sampled at the clock edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got_out = out_data_o;
        if (pending_outputs.size() == 0) begin
          $error("Result item arrived with nothing expected");
          error_count++;
        end else begin
          want_out = pending_outputs.pop_front();
          results_checked++;
          check_field("lamp1", want_out.lamp1, got_out.lamp1);
          check_field("lamp2", want_out.lamp2, got_out.lamp2);
          check_field("lamp3", want_out.lamp3, got_out.lamp3);
          check_field("relay_on", want_out.relay_on, got_out.relay_on);
          check_field("rpm_square", want_out.rpm_square, got_out.rpm_square);
          check_field("fan1_ok", want_out.fan1_ok, got_out.fan1_ok);
          check_field("fan2_ok", want_out.fan2_ok, got_out.fan2_ok);
          check_field("status", want_out.status, got_out.status);
          check_field("reset_request", want_out.reset_request, got_out.reset_request);
        end
      end
      if (in_valid_i && in_ready_o) begin
        want_out = predict_outputs(in_data_i);
        events_seen++;
        pending_outputs.push_back(row_typed ? row_want : want_out);
      end
    end
  end

  // Result side: random back-pressure, plus one long hold-off on request.
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_ready_i <= 1'b0;
    end else if (hold_cycles != 0) begin
      out_ready_i <= 1'b0;
      hold_cycles--;
    end else if (hold_off_req) begin
      hold_off_req = 1'b0;
      hold_cycles = HOLD_OFF_CYCLES;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= calm || ($urandom_range(99) >= 34);
    end
  end

  // Offers one item, with random idle cycles ahead of it, and returns once taken.
  task automatic send_event(input in_t ev, input logic typed, input out_t want);
    while (!calm && $urandom_range(99) < 34) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= ev;
    row_typed  <= typed;
    row_want   <= want;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
  endtask

  // Stops offering items and waits until every result has come back.
  task automatic wait_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (pending_outputs.size() != 0) @(posedge clk_i);
    repeat (2) @(posedge clk_i);
  endtask

  // Leaves the valid high, so that writes can follow back to back.
  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_DATA_WIDTH-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      CFG_FAN1_MIN:   regs.fan1_min   = val;
      CFG_FAN2_MIN:   regs.fan2_min   = val;
      CFG_TOTAL_MIN:  regs.total_min  = val;
      CFG_SPUR_LIMIT: regs.spur_limit = val[SPUR_WIDTH-1:0];
      CFG_LEVEL1:     regs.level1     = val[LEVEL_WIDTH-1:0];
      CFG_LEVEL2:     regs.level2     = val[LEVEL_WIDTH-1:0];
      CFG_ALT_BLINK:  regs.alt_blink  = val[0];
      default: ;
    endcase
  endtask

  // Narrow registers get junk in the unused upper bits, which must be ignored.
  task automatic load_regs(input cfg_t c);
    write_reg(CFG_FAN1_MIN, c.fan1_min);
    write_reg(CFG_FAN2_MIN, c.fan2_min);
    write_reg(CFG_TOTAL_MIN, c.total_min);
    write_reg(CFG_SPUR_LIMIT, {8'($urandom), c.spur_limit});
    write_reg(CFG_LEVEL1, {8'($urandom), c.level1});
    write_reg(CFG_LEVEL2, {8'($urandom), c.level2});
    write_reg(CFG_ALT_BLINK, {15'($urandom), c.alt_blink});
    cfg_valid_i <= 1'b0;
  endtask

  function automatic cfg_t phase_regs(int unsigned phase);
    cfg_t c;
    c = '{fan1_min: FAN1_MIN_RESET, fan2_min: FAN2_MIN_RESET, total_min: TOTAL_MIN_RESET,
          spur_limit: SPUR_LIMIT_RESET, level1: LEVEL1_RESET, level2: LEVEL2_RESET,
          alt_blink: 1'b1};
    case (phase)
      0: ;
      1: c = '{16'd0, 16'd0, 16'd0, 8'd255, 8'd0, 8'd255, 1'b0};
      2: c = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 8'd254, 8'd255, 8'd0, 1'b1};
      3: c = '{16'd3, 16'd5, 16'd7, 8'd4, 8'd100, 8'd30, 1'b0};
      default: begin
        c.fan1_min   = MIN_WIDTH'($urandom_range(20));
        c.fan2_min   = MIN_WIDTH'($urandom_range(20));
        c.total_min  = MIN_WIDTH'($urandom_range(40));
        c.spur_limit = SPUR_WIDTH'($urandom_range(255));
        c.level1     = LEVEL_WIDTH'($urandom);
        c.level2     = LEVEL_WIDTH'($urandom);
        c.alt_blink  = 1'($urandom);
      end
    endcase
    return c;
  endfunction

  // Mostly busy events with random flags; the pulse rate changes at each window
  // so that slow and normal windows both turn up.
  function automatic in_t random_event();
    in_t ev;
    ev = '0;
    if ($urandom_range(99) < 4) return ev;
    ev.tach1_edge   = $urandom_range(99) < pulse_pct;
    ev.tach2_edge   = $urandom_range(99) < pulse_pct;
    ev.serial_event = $urandom_range(99) < 15;
    ev.pwm_tick     = $urandom_range(99) < 50;
    ev.window_tick  = $urandom_range(99) < 4;
    if (ev.window_tick) begin
      case ($urandom_range(3))
        0: pulse_pct = 5;
        1: pulse_pct = 30;
        2: pulse_pct = 60;
        default: pulse_pct = 90;
      endcase
    end
    return ev;
  endfunction

  initial begin : stimulus
    in_t         both_pulses;
    in_t         win_only;
    int unsigned burst;
    regs = phase_regs(0);
    clear_fan_state();
    both_pulses = '0;
    both_pulses.tach1_edge = 1'b1;
    both_pulses.tach2_edge = 1'b1;
    win_only = '0;
    win_only.window_tick = 1'b1;
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, run with a spurious limit of zero, so the second spurious event resets the state.
    write_reg(CFG_SPUR_LIMIT, 16'd0);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
    foreach (DIRECTED_ROWS[r]) begin
      send_event(DIRECTED_ROWS[r].ev, DIRECTED_ROWS[r].typed, DIRECTED_ROWS[r].want);
    end
    wait_idle();

    // Random phases, each with its own register settings.
    for (int unsigned p = 0; p < PHASE_COUNT; p++) begin
      load_regs(phase_regs(p));
      @(posedge clk_i);
      if (p == 1) begin
        // A whole phase at full rate; the spurious counter runs into its ceiling.
        calm = 1'b1;
        repeat (SPUR_BURST) send_event('0, 1'b0, QUIET_OUT);
      end else if (p == 2) begin
        // A dense pulse run against the largest minimums; the window stays slow.
        calm = 1'b1;
        repeat (PULSE_BURST) send_event(both_pulses, 1'b0, QUIET_OUT);
        send_event(win_only, 1'b0, QUIET_OUT);
        calm = 1'b0;
      end
      for (int unsigned n = 0; n < PHASE_ITEMS[p]; n++) begin
        if (p == 3 && n == 100) hold_off_req = 1'b1;
        if ($urandom_range(99) == 0) begin
          burst = $urandom_range(20, 5);
          repeat (burst) send_event('0, 1'b0, QUIET_OUT);
        end
        send_event(random_event(), 1'b0, QUIET_OUT);
      end
      wait_idle();
      calm = 1'b0;
    end

    wait_idle();
    $display("Checked %0d results from %0d items: %0d windows, %0d of them normal.",
             results_checked, events_seen, windows_done, normal_windows);
    $display("Spurious resets seen: %0d; the spurious counter was run up to its ceiling once.",
             resets_done);
    if (error_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

  // Watchdog for a hung handshake.
  initial begin
    #10_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

endmodule

### sim.f
rtl/dftm_pkg.sv
rtl/dftm_step.sv
rtl/dual_fan_tach_monitor_top.sv
dv/dual_fan_tach_monitor_top_tb.sv
